>>> src/gods_pkg.sv
package gods_pkg;

  // Field and state widths.
  localparam int SAMPLE_W = 16;
  localparam int RATE_W   = 23;
  localparam int FS_W     = 2;
  localparam int PHASE_W  = 2;
  localparam int SUM_W    = 24;
  localparam int OFF_W    = 25;
  localparam int THR_W    = 17;
  localparam int COUNT_W  = 9;

  // Fraction bits of the Q8 offset and delta.
  localparam int FRAC_W   = 8;

  // Datapath widths: delta = sample * 256 - offset, and its magnitude.
  localparam int DELTA_W  = 26;
  localparam int MAG_W    = 25;
  localparam int MULT_W   = 6;

  // Offset division: dividend is |sum| * 256, quotient fits the offset magnitude,
  // and the reciprocal of the sample count needs one bit above the dividend width.
  localparam int DIV_W    = SUM_W + FRAC_W;
  localparam int QUO_W    = 24;
  localparam int RECIP_W  = DIV_W + 1;

  // Full-scale codes.
  localparam logic [FS_W-1:0] FS_250  = 2'd0;
  localparam logic [FS_W-1:0] FS_500  = 2'd1;
  localparam logic [FS_W-1:0] FS_2000 = 2'd2;

  typedef enum logic [PHASE_W-1:0] {
    PH_OFFSET = 2'd0,
    PH_THRESH = 2'd1,
    PH_RUN    = 2'd2
  } phase_t;

  // Per-axis result of the combinational datapath.
  typedef struct packed {
    logic [THR_W-1:0]         dev;
    logic signed [RATE_W-1:0] rate;
  } axis_res_t;

  // Rate multiplier for a full-scale code; the unused code acts as 250 dps.
  function automatic logic [MULT_W-1:0] fs_mult(input logic [FS_W-1:0] fs);
    logic [MULT_W-1:0] m;
    case (fs)
      FS_500:  m = 6'd14;
      FS_2000: m = 6'd56;
      default: m = 6'd7;
    endcase
    return m;
  endfunction

endpackage

>>> src/gods_axis.sv
module gods_axis (
  input  logic signed [gods_pkg::SAMPLE_W-1:0] sample,
  input  logic signed [gods_pkg::OFF_W-1:0]    off_q8,
  input  logic [gods_pkg::THR_W-1:0]           thr,
  input  logic [gods_pkg::MULT_W-1:0]          mult,
  output gods_pkg::axis_res_t                  res
);

  localparam int DW = gods_pkg::DELTA_W;
  localparam int MW = gods_pkg::MAG_W;
  localparam int FW = gods_pkg::FRAC_W;
  localparam int PW = gods_pkg::DELTA_W + gods_pkg::MULT_W + 1;
  localparam int RW = gods_pkg::RATE_W;

  logic signed [DW-1:0]                delta;
  logic [MW-1:0]                       mag;
  logic                                in_band;
  logic signed [gods_pkg::MULT_W:0]    mult_s;
  logic signed [PW-1:0]                prod;
  logic signed [PW-1:0]                prod_adj;

  // Delta in Q8 and its magnitude.
  always_comb begin
    delta = ((DW)'(sample) <<< FW) - (DW)'(off_q8);
    mag   = delta[DW-1] ? (MW)'(-delta) : (MW)'(delta);
  end

  // Deadband test against the threshold scaled to Q8.
  assign in_band = mag < {thr, {FW{1'b0}}};

  // Scale and drop the fraction, rounding toward zero.
  always_comb begin
    mult_s   = $signed({1'b0, mult});
    prod     = (PW)'(delta) * (PW)'(mult_s);
    prod_adj = prod + (prod[PW-1] ? (PW)'((1 << FW) - 1) : '0);
  end

  assign res.dev  = mag[MW-1:FW];
  assign res.rate = in_band ? '0 : (RW)'(prod_adj >>> FW);

endmodule

>>> src/gods_div.sv
module gods_div #(
  parameter int CAL_SAMPLES = 100
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [gods_pkg::SUM_W-1:0] sum [3],
  output logic                              busy,
  output logic signed [gods_pkg::OFF_W-1:0] off_q8 [3]
);

  localparam int SW    = gods_pkg::SUM_W;
  localparam int QW    = gods_pkg::QUO_W;
  localparam int MW    = gods_pkg::RECIP_W;
  localparam int PW    = gods_pkg::SUM_W + gods_pkg::RECIP_W;
  localparam int LOG_D = $clog2(CAL_SAMPLES);
  localparam int SHIFT = gods_pkg::DIV_W + LOG_D - gods_pkg::FRAC_W;

  // Rounded-up reciprocal; exact truncated quotient for any dividend below 2^DIV_W.
  localparam longint unsigned RECIP =
    ((64'd1 << (gods_pkg::DIV_W + LOG_D)) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES);
  localparam logic [MW-1:0] RECIP_M = (MW)'(RECIP);

  logic [1:0]    stage;
  logic          neg [3];
  logic [SW-1:0] sum_mag [3];
  logic [SW-1:0] dvd [3];
  logic [PW-1:0] prod [3];
  logic [QW-1:0] quo [3];

  // Magnitude of each sum, and the reciprocal product of the registered magnitude.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_mag[i] = sum[i][SW-1] ? (SW)'(-sum[i]) : (SW)'(sum[i]);
      prod[i]    = (PW)'(dvd[i]) * (PW)'(RECIP_M);
    end
  end

  // Busy while the quotient magnitude, then the signed offset, is formed.
  assign busy = |stage;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= '0;
    end else begin
      stage <= {stage[0], start};
    end
  end

  // Magnitude and sign are taken at start; the signed offset is written on the last cycle.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (start) begin
        neg[i] <= sum[i][SW-1];
        dvd[i] <= sum_mag[i];
      end
      if (stage[0]) begin
        quo[i] <= prod[i][SHIFT +: QW];
      end
      if (stage[1]) begin
        off_q8[i] <= neg[i] ? -$signed({1'b0, quo[i]}) : $signed({1'b0, quo[i]});
      end
    end
  end

endmodule

>>> src/gyro_offset_deadband_scaler_core.sv
// Channel   Handshake                Payload
// cfg       cfg_valid / cfg_ready    full_scale_select
// in        in_valid / in_ready      x_sample, y_sample, z_sample, restart
// out       out_valid / out_ready    x_rate, y_rate, z_rate, phase
//
// One item per cycle unless stalled; each item passes an input and a result register.
// After the last offset-calibration sample, input is held off while the
// three offsets are formed by reciprocal multiplication, magnitude first, then sign.
// Synchronous reset clears control, calibration state and the full-scale register.
// A stalled result register holds the input register, which holds off new items.
module gyro_offset_deadband_scaler_core #(
  parameter int CAL_SAMPLES = 100
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [gods_pkg::FS_W-1:0]            full_scale_select,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [gods_pkg::SAMPLE_W-1:0] x_sample,
  input  logic signed [gods_pkg::SAMPLE_W-1:0] y_sample,
  input  logic signed [gods_pkg::SAMPLE_W-1:0] z_sample,
  input  logic                                 restart,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [gods_pkg::RATE_W-1:0]   x_rate,
  output logic signed [gods_pkg::RATE_W-1:0]   y_rate,
  output logic signed [gods_pkg::RATE_W-1:0]   z_rate,
  output logic [gods_pkg::PHASE_W-1:0]         phase
);

  localparam int SW = gods_pkg::SUM_W;
  localparam int CW = gods_pkg::COUNT_W;
  localparam int TW = gods_pkg::THR_W;
  localparam int RW = gods_pkg::RATE_W;
  localparam logic [CW-1:0] CAL_COUNT = (CW)'(CAL_SAMPLES);

  logic [gods_pkg::FS_W-1:0]            fs_sel;
  logic                                 a_valid;
  logic signed [gods_pkg::SAMPLE_W-1:0] a_sample [3];
  logic                                 a_restart;
  logic signed [SW-1:0]                 sum [3];
  logic [TW-1:0]                        thr [3];
  gods_pkg::phase_t                     cal_phase;
  logic [CW-1:0]                        count;

  logic                                 b_free;
  logic                                 a_move;
  gods_pkg::phase_t                     cur_phase;
  logic [CW-1:0]                        cur_count;
  logic [CW-1:0]                        count_inc;
  logic                                 last;
  logic signed [SW-1:0]                 cur_sum [3];
  logic [TW-1:0]                        cur_thr [3];
  logic signed [SW-1:0]                 sum_next [3];
  logic [TW-1:0]                        thr_next [3];
  logic [gods_pkg::PHASE_W-1:0]         handled;
  logic                                 div_start;
  logic                                 div_busy;
  logic signed [gods_pkg::OFF_W-1:0]    off_q8 [3];
  gods_pkg::axis_res_t                  res [3];
  logic [gods_pkg::MULT_W-1:0]          mult;

  // Handshake: the input register moves when result register and divider are free.
  assign cfg_ready = 1'b1;
  assign b_free    = !out_valid || out_ready;
  assign a_move    = a_valid && b_free && !div_busy;
  assign in_ready  = !a_valid || a_move;
  assign mult      = gods_pkg::fs_mult(fs_sel);

  // Calibration state as seen by the current item, after a possible restart.
  always_comb begin
    cur_phase = a_restart ? gods_pkg::PH_OFFSET : cal_phase;
    cur_count = a_restart ? '0 : count;
    count_inc = cur_count + 1'b1;
    last      = count_inc == CAL_COUNT;
    for (int i = 0; i < 3; i++) begin
      cur_sum[i]  = a_restart ? '0 : sum[i];
      cur_thr[i]  = a_restart ? '0 : thr[i];
      sum_next[i] = cur_sum[i] + (SW)'(a_sample[i]);
      thr_next[i] = (res[i].dev > cur_thr[i]) ? res[i].dev : cur_thr[i];
    end
    case (cur_phase)
      gods_pkg::PH_OFFSET: handled = gods_pkg::PH_OFFSET;
      gods_pkg::PH_THRESH: handled = gods_pkg::PH_THRESH;
      default:             handled = gods_pkg::PH_RUN;
    endcase
  end

  assign div_start = a_move && (cur_phase == gods_pkg::PH_OFFSET) && last;

  // Per-axis delta, deadband and scaling.
  for (genvar g = 0; g < 3; g++) begin : g_axis
    gods_axis u_axis (
      .sample (a_sample[g]),
      .off_q8 (off_q8[g]),
      .thr    (cur_thr[g]),
      .mult   (mult),
      .res    (res[g])
    );
  end

  // Offset divider, started when offset calibration completes.
  gods_div #(
    .CAL_SAMPLES (CAL_SAMPLES)
  ) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .sum    (sum_next),
    .busy   (div_busy),
    .off_q8 (off_q8)
  );

  // Control and calibration state.
  always_ff @(posedge clk) begin
    if (rst) begin
      fs_sel    <= gods_pkg::FS_250;
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
      cal_phase <= gods_pkg::PH_OFFSET;
      count     <= '0;
      for (int i = 0; i < 3; i++) begin
        sum[i] <= '0;
        thr[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        fs_sel <= full_scale_select;
      end
      if (in_ready) begin
        a_valid <= in_valid;
      end
      if (a_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (a_move) begin
        case (cur_phase)
          gods_pkg::PH_OFFSET: begin
            for (int i = 0; i < 3; i++) begin
              sum[i] <= sum_next[i];
              thr[i] <= cur_thr[i];
            end
            count     <= last ? '0 : count_inc;
            cal_phase <= last ? gods_pkg::PH_THRESH : gods_pkg::PH_OFFSET;
          end
          gods_pkg::PH_THRESH: begin
            for (int i = 0; i < 3; i++) begin
              thr[i] <= thr_next[i];
            end
            count     <= last ? '0 : count_inc;
            cal_phase <= last ? gods_pkg::PH_RUN : gods_pkg::PH_THRESH;
          end
          default: begin
            cal_phase <= cur_phase;
          end
        endcase
      end
    end
  end

  // Input and result payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_sample[0] <= x_sample;
      a_sample[1] <= y_sample;
      a_sample[2] <= z_sample;
      a_restart   <= restart;
    end
    if (a_move) begin
      phase  <= handled;
      x_rate <= (handled == gods_pkg::PH_RUN) ? res[0].rate : (RW)'(0);
      y_rate <= (handled == gods_pkg::PH_RUN) ? res[1].rate : (RW)'(0);
      z_rate <= (handled == gods_pkg::PH_RUN) ? res[2].rate : (RW)'(0);
    end
  end

`ifndef SYNTHESIS
  a_no_move_while_dividing: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> !a_move)
    else $error("item moved while the offset divider was busy");

  a_cal_rates_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && phase != gods_pkg::PH_RUN) |->
      (x_rate == '0 && y_rate == '0 && z_rate == '0))
    else $error("nonzero rate during calibration");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    count < CAL_COUNT)
    else $error("sample count reached the calibration length");

  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(div_busy) |-> $past(div_start))
    else $error("divider started without a completed offset calibration");
`endif

endmodule
